// ===== rtl/fcu_pkg.sv =====
// Package with the field layout, defaults and register map of the flagged cell unpacker.
`timescale 1ns / 1ps
`default_nettype none

package fcu_pkg;

   localparam int unsigned FIELD_COUNT = 5;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned ADDR_W      = 3;

   typedef logic [FIELD_COUNT-1:0]             flags_type;
   typedef logic [FIELD_COUNT-1:0][BYTE_W-1:0] cell_type;
   typedef logic [COUNT_W-1:0]                 count_type;

   // Only the low five bits of a flag byte select fields.
   localparam flags_type FLAG_MASK = 5'h1F;

   // Field 0 is the instrument and sits in the lowest byte.
   localparam cell_type CELL_DEFAULT = {8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00};

   localparam count_type CELLS_RESET = 16'd256;

   typedef enum logic {
      REG_CELLS_PER_PATTERN = 1'b0,
      REG_UNUSED            = 1'b1
   } reg_index_type;

endpackage

`default_nettype wire

// ===== rtl/flagged_cell_unpacker.sv =====
// A cell appears on rsp in the cycle after the beat that completes it.
// Throughput: one stream byte per cycle; the single output register lets a new
// byte in whenever it is empty or being drained in the same cycle.
// Reset (synchronous, active high) clears the field tracking and cell counter,
// empties the output register and sets cells_per_pattern to 256.
// Pattern data registers need no reset; a flag byte always reloads them.
`timescale 1ns / 1ps
`default_nettype none

module flagged_cell_unpacker
   import fcu_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // Stream bytes in.
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [7:0] stream_byte
   // Unpacked cells out.
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // [7:0] instrument, [15:8] note_value, [23:16] effect_code,
   // [31:24] effect_arg, [39:32] volume
   output logic [39:0]              rsp_tdata,
   output logic                     rsp_tlast,   // last_cell
   // Register port.
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   flags_type     pending_ff, pending_in;
   cell_type      fields_ff, fields_in;
   count_type     count_ff, count_in;
   count_type     cells_ff;
   logic          out_valid_ff, out_valid_in;
   cell_type      out_cell_ff;
   logic          out_last_ff;
   logic          accept;
   logic          emit;
   logic          last;
   flags_type     low_pick;
   logic [COUNT_W:0] count_next;
   reg_index_type reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[ADDR_W-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= CELLS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   reg_index == REG_CELLS_PER_PATTERN) begin
         cells_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      case (reg_index)
         REG_CELLS_PER_PATTERN: csr_prdata = {{(32-COUNT_W){1'b0}}, cells_ff};
         default:               csr_prdata = '0;
      endcase
   end

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // The lowest pending field takes the byte.
   assign low_pick = pending_ff & (~pending_ff + flags_type'(1));

   always_comb begin
      fields_in  = fields_ff;
      pending_in = pending_ff;
      if (pending_ff == '0) begin
         fields_in  = CELL_DEFAULT;
         pending_in = req_tdata[FIELD_COUNT-1:0] & FLAG_MASK;
      end else begin
         for (int i = 0; i < FIELD_COUNT; i++) begin
            if (low_pick[i]) begin
               fields_in[i] = req_tdata;
            end
         end
         pending_in = pending_ff & ~low_pick;
      end
      emit = (pending_in == '0);
   end

   // A pattern size of zero, or one lowered below the count, ends the pattern now.
   assign count_next = {1'b0, count_ff} + {{COUNT_W{1'b0}}, 1'b1};
   assign last       = count_next >= {1'b0, cells_ff};
   assign count_in   = last ? '0 : count_next[COUNT_W-1:0];

   always_comb begin
      out_valid_in = out_valid_ff;
      if (accept && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (accept) begin
            pending_ff <= pending_in;
            if (emit) begin
               count_ff <= count_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fields_ff <= fields_in;
         if (emit) begin
            out_cell_ff <= fields_in;
            out_last_ff <= last;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_cell_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef ASSERT_OFF
   // A waiting last cell means the counter has already wrapped.
   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> count_ff == '0)
      else $error("last cell shown but cell counter not wrapped");

   // A flag byte with no field bits produces a cell on the next cycle.
   a_empty_flag_emits: assert property (@(posedge clock) disable iff (reset)
      accept && pending_ff == '0 && (req_tdata[FIELD_COUNT-1:0] & FLAG_MASK) == '0
      |=> rsp_tvalid)
      else $error("empty flag byte did not produce a cell");

   // The byte for the final pending field completes the cell.
   a_final_field_emits: assert property (@(posedge clock) disable iff (reset)
      accept && $onehot(pending_ff) |=> rsp_tvalid && pending_ff == '0)
      else $error("final field byte did not complete the cell");
`endif

endmodule

`default_nettype wire
